// ===== rtl/tnf_pkg.sv =====
// tnf_pkg: shared types and constants for the telnet receive filter
// no dependencies
`default_nettype none

package tnf_pkg;

  localparam logic [7:0] TnIac  = 8'd255;
  localparam logic [7:0] TnDont = 8'd254;
  localparam logic [7:0] TnDo   = 8'd253;
  localparam logic [7:0] TnWont = 8'd252;
  localparam logic [7:0] TnWill = 8'd251;
  localparam logic [7:0] TnSb   = 8'd250;
  localparam logic [7:0] TnSe   = 8'd240;
  localparam logic [7:0] TnNaws = 8'd31;

  typedef enum logic [3:0] {
    ST_DATA   = 4'd0,
    ST_OPTION = 4'd1,
    ST_SUB    = 4'd2,
    ST_SUBIAC = 4'd3,
    ST_COLHI  = 4'd4,
    ST_COLLO  = 4'd5,
    ST_ROWHI  = 4'd6,
    ST_ROWLO  = 4'd7,
    ST_IAC    = 4'd8
  } parse_state_e;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_SIZE = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_of_chunk;
  } tnf_in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] columns;
    logic [7:0] rows;
  } tnf_out_t;

  typedef struct packed {
    logic     valid;
    tnf_out_t beat;
  } tnf_res_t;

endpackage

`default_nettype wire

// ===== rtl/telnet_receive_filter_naws_unit.sv =====
// an accepted byte is held in in_q, parsed, and its result beat registered in out_q
// throughput: one byte per cycle unless out_ready_i stalls the single parse stage
// bytes that cause no result (commands, options, subnegotiation) still go through parsing
// reset: rst_ni low clears the parse state, captured size, pending flag and both valids
// depends on tnf_pkg and tnf_parser
`default_nettype none

module telnet_receive_filter_naws_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire tnf_pkg::tnf_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output tnf_pkg::tnf_out_t      out_data_o
);

  logic              in_valid_q;
  tnf_pkg::tnf_in_t  in_q;
  logic              out_valid_q;
  tnf_pkg::tnf_out_t out_q;
  logic              fire;
  tnf_pkg::tnf_res_t res;

  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  tnf_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .rx_byte_i (in_q.rx_byte),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= res.valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res.valid) begin
      out_q <= res.beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_no_fire_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !fire)
    else $error("parse stage advanced into a full output register");
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !fire) |=> (in_valid_q && $stable(in_q)))
    else $error("stalled input stage lost its beat");
  a_out_from_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && !fire) |=> !out_valid_q)
    else $error("output beat appeared without a parse step");
`endif

endmodule

`default_nettype wire

// ===== rtl/tnf_parser.sv =====
// tnf_parser: telnet parse state, window-size capture and per-byte result logic
// depends on tnf_pkg
`default_nettype none

module tnf_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire logic [7:0]       rx_byte_i,
  output tnf_pkg::tnf_res_t     res_o
);

  tnf_pkg::parse_state_e state_q, state_d;
  logic [7:0] cols_q, cols_d;
  logic [7:0] rows_q, rows_d;
  logic       pend_q, pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tnf_pkg::ST_DATA;
      cols_q  <= 8'd0;
      rows_q  <= 8'd0;
      pend_q  <= 1'b0;
    end else if (fire_i) begin
      state_q <= state_d;
      cols_q  <= cols_d;
      rows_q  <= rows_d;
      pend_q  <= pend_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cols_d  = cols_q;
    rows_d  = rows_q;
    pend_d  = pend_q;
    res_o   = '0;
    unique case (state_q)
      tnf_pkg::ST_IAC: begin
        if (rx_byte_i == tnf_pkg::TnDo || rx_byte_i == tnf_pkg::TnDont ||
            rx_byte_i == tnf_pkg::TnWill || rx_byte_i == tnf_pkg::TnWont) begin
          state_d = tnf_pkg::ST_OPTION;
        end else if (rx_byte_i == tnf_pkg::TnSb) begin
          state_d = tnf_pkg::ST_SUB;
        end else if (rx_byte_i == tnf_pkg::TnIac) begin
          res_o.valid          = 1'b1;
          res_o.beat.kind      = tnf_pkg::KIND_DATA;
          res_o.beat.data_byte = tnf_pkg::TnIac;
          state_d = tnf_pkg::ST_DATA;
        end else begin
          state_d = tnf_pkg::ST_DATA;
        end
      end
      tnf_pkg::ST_OPTION: begin
        state_d = tnf_pkg::ST_DATA;
      end
      tnf_pkg::ST_SUB: begin
        if (rx_byte_i == tnf_pkg::TnIac) begin
          state_d = tnf_pkg::ST_SUBIAC;
        end else if (rx_byte_i == tnf_pkg::TnNaws) begin
          state_d = tnf_pkg::ST_COLHI;
        end
      end
      tnf_pkg::ST_SUBIAC: begin
        if (pend_q) begin
          pend_d             = 1'b0;
          res_o.valid        = 1'b1;
          res_o.beat.kind    = tnf_pkg::KIND_SIZE;
          res_o.beat.columns = cols_q;
          res_o.beat.rows    = rows_q;
        end
        state_d = (rx_byte_i == tnf_pkg::TnSe) ? tnf_pkg::ST_DATA : tnf_pkg::ST_SUB;
      end
      tnf_pkg::ST_COLHI: begin
        state_d = (rx_byte_i != 8'd0) ? tnf_pkg::ST_SUBIAC : tnf_pkg::ST_COLLO;
      end
      tnf_pkg::ST_COLLO: begin
        cols_d  = rx_byte_i;
        state_d = tnf_pkg::ST_ROWHI;
      end
      tnf_pkg::ST_ROWHI: begin
        if (rx_byte_i != 8'd0) begin
          state_d = tnf_pkg::ST_SUBIAC;
        end else begin
          pend_d  = 1'b1;
          state_d = tnf_pkg::ST_ROWLO;
        end
      end
      tnf_pkg::ST_ROWLO: begin
        rows_d  = rx_byte_i;
        state_d = tnf_pkg::ST_SUB;
      end
      default: begin
        if (rx_byte_i == tnf_pkg::TnIac) begin
          state_d = tnf_pkg::ST_IAC;
        end else begin
          res_o.valid          = 1'b1;
          res_o.beat.kind      = tnf_pkg::KIND_DATA;
          res_o.beat.data_byte = rx_byte_i;
          state_d = tnf_pkg::ST_DATA;
        end
      end
    endcase
  end

`ifndef SYNTHESIS
  a_report_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.beat.kind == tnf_pkg::KIND_SIZE) |->
      (state_q == tnf_pkg::ST_SUBIAC && pend_q))
    else $error("size report outside pending subnegotiation iac");
  a_cols_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && state_q == tnf_pkg::ST_COLLO) |=> (cols_q == $past(rx_byte_i)))
    else $error("columns not captured");
  a_pend_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && state_q == tnf_pkg::ST_ROWHI && rx_byte_i == 8'd0) |=>
      (pend_q && state_q == tnf_pkg::ST_ROWLO))
    else $error("pending flag not set on rows high byte");
`endif

endmodule

`default_nettype wire

// ===== tb/tnf_stream_checker.sv =====
// tnf_stream_checker: watches both channels of the telnet receive filter, predicts each
// result beat from the accepted input bytes and compares them field by field
// depends on tnf_pkg
module tnf_stream_checker
  import tnf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  tnf_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  tnf_out_t out_data_i,
  output int       mismatch_count_o,
  output int       beats_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  parse_state_e model_state;
  logic [7:0]   naws_columns;
  logic [7:0]   naws_rows;
  logic         size_waiting;
  tnf_out_t     due_beats [$];
  int           mismatches = 0;

  task automatic filter_byte(input logic [7:0] b);
    tnf_out_t res;
    logic     emit;
    res  = '0;
    emit = 1'b0;
    case (model_state)
      ST_IAC: begin
        if (b == TnDo || b == TnDont || b == TnWill || b == TnWont) begin
          model_state = ST_OPTION;
        end else if (b == TnSb) begin
          model_state = ST_SUB;
        end else if (b == TnIac) begin
          res.kind      = KIND_DATA;
          res.data_byte = TnIac;
          emit          = 1'b1;
          model_state   = ST_DATA;
        end else begin
          model_state = ST_DATA;
        end
      end
      ST_OPTION: model_state = ST_DATA;
      ST_SUB: begin
        if (b == TnNaws) begin
          model_state = ST_COLHI;
        end else if (b == TnIac) begin
          model_state = ST_SUBIAC;
        end
      end
      ST_SUBIAC: begin
        if (size_waiting) begin
          size_waiting = 1'b0;
          res.kind     = KIND_SIZE;
          res.columns  = naws_columns;
          res.rows     = naws_rows;
          emit         = 1'b1;
        end
        if (b == TnSe) begin
          model_state = ST_DATA;
        end else begin
          model_state = ST_SUB;
        end
      end
      ST_COLHI: begin
        if (b != 8'h00) begin
          model_state = ST_SUBIAC;
        end else begin
          model_state = ST_COLLO;
        end
      end
      ST_COLLO: begin
        naws_columns = b;
        model_state  = ST_ROWHI;
      end
      ST_ROWHI: begin
        if (b != 8'h00) begin
          model_state = ST_SUBIAC;
        end else begin
          size_waiting = 1'b1;
          model_state  = ST_ROWLO;
        end
      end
      ST_ROWLO: begin
        naws_rows   = b;
        model_state = ST_SUB;
      end
      default: begin
        if (b == TnIac) begin
          model_state = ST_IAC;
        end else begin
          res.kind      = KIND_DATA;
          res.data_byte = b;
          emit          = 1'b1;
          model_state   = ST_DATA;
        end
      end
    endcase
    if (emit) due_beats.push_back(res);
  endtask

  function automatic int field_differs(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i) begin
    tnf_out_t want;
    int       bad;
    if (!rst_ni) begin
      model_state  = ST_DATA;
      naws_columns = 8'h00;
      naws_rows    = 8'h00;
      size_waiting = 1'b0;
      due_beats.delete();
    end else begin
      if (in_valid_i && in_ready_i) filter_byte(in_data_i.rx_byte);
      if (out_valid_i && out_ready_i) begin
        if (due_beats.size() == 0) begin
          $display("%0t: beat with none expected, actual kind %0d data %0d columns %0d rows %0d",
                   $time, out_data_i.kind, out_data_i.data_byte, out_data_i.columns,
                   out_data_i.rows);
          mismatches++;
        end else begin
          want = due_beats.pop_front();
          bad  = field_differs("kind", 8'(want.kind), 8'(out_data_i.kind))
               + field_differs("data_byte", want.data_byte, out_data_i.data_byte)
               + field_differs("columns", want.columns, out_data_i.columns)
               + field_differs("rows", want.rows, out_data_i.rows);
          if (bad != 0) mismatches++;
        end
      end
    end
    mismatch_count_o <= mismatches;
    beats_due_o      <= due_beats.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: byte stimulus with bursty sending and receiver stalls for the telnet receive filter
// depends on tnf_pkg, telnet_receive_filter_naws_unit and tnf_stream_checker
module tb_top;
  import tnf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  tnf_in_t  in_data   = '0;
  logic     out_ready = 1'b0;
  logic     in_ready;
  logic     out_valid;
  tnf_out_t out_data;
  int       mismatches;
  int       beats_due;

  int sent_count  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  int stall_tick  = 0;
  int stall_mode  = 0;

  logic [7:0] opening_bytes [$] = '{
    TnIac, TnIac, 8'h00,
    TnIac, TnDo, 8'h00,
    TnIac, TnDont, 8'hFF,
    TnIac, TnWill, TnNaws,
    TnIac, TnWont, 8'h80,
    TnIac, 8'hF1,
    TnIac, TnSb, TnNaws, 8'h00, 8'd80, 8'h00, 8'd24, TnIac, 8'h7E,
    TnNaws, 8'h05, TnSe
  };

  always #1 clk = ~clk;

  telnet_receive_filter_naws_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  tnf_stream_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatches),
    .beats_due_o      (beats_due)
  );

  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 256 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (stall_tick % 7 < 4);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= 2000) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [7:0] b);
    tnf_in_t beat;
    int      gap;
    beat.rx_byte       = b;
    beat.last_of_chunk = ($urandom_range(0, 5) == 0);
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap        = $urandom_range(0, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    int         pick;
    int         n;
    logic [7:0] hi;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_bytes[i]) send_beat(opening_bytes[i]);

    while (sent_count < 1750) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        n = $urandom_range(1, 8);
        repeat (n) send_beat(8'($urandom_range(0, 254)));
      end else if (pick < 45) begin
        send_beat(TnIac);
        send_beat(TnIac);
      end else if (pick < 58) begin
        send_beat(TnIac);
        case ($urandom_range(0, 3))
          0: send_beat(TnDo);
          1: send_beat(TnDont);
          2: send_beat(TnWill);
          default: send_beat(TnWont);
        endcase
        send_beat(8'($urandom));
      end else if (pick < 63) begin
        send_beat(TnIac);
        send_beat(8'($urandom_range(0, 249)));
      end else if (pick < 92) begin
        send_beat(TnIac);
        send_beat(TnSb);
        repeat ($urandom_range(0, 2)) send_beat(8'($urandom_range(32, 254)));
        n = $urandom_range(1, 2);
        repeat (n) begin
          send_beat(TnNaws);
          hi = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
          send_beat(hi);
          send_beat(8'($urandom));
          hi = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
          send_beat(hi);
          send_beat(8'($urandom));
          if ($urandom_range(0, 3) == 0) begin
            send_beat(TnIac);
            send_beat(8'($urandom_range(0, 239)));
          end
        end
        send_beat(TnIac);
        send_beat(($urandom_range(0, 7) == 0) ? 8'($urandom) : TnSe);
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_beat(8'($urandom));
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (beats_due != 0);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
